>>> rtl/can_multiframe_reassembler_unit_defines.svh
// Assertion macros shared by the reassembler modules.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef CAN_MULTIFRAME_REASSEMBLER_UNIT_DEFINES_SVH
`define CAN_MULTIFRAME_REASSEMBLER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CMR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CMR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/cmr_pkg.sv
package cmr_pkg;

	// Field widths of the stream words.
	localparam int ID_W      = 29;
	localparam int FNUM_W    = 5;
	localparam int PAYLOAD_W = 64;
	localparam int TIME_W    = 32;
	localparam int TIMEOUT_W = 16;
	localparam int COUNT_W   = 8;
	localparam int INDEX_W   = 4;
	localparam int WORD_W    = 32;

	// Packed stream widths, rounded up to whole bytes.
	localparam int S_TDATA_W = 128;
	localparam int M_TDATA_W = 40;

	// Configuration registers.
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = ID_W;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_ID    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS = 1'b1;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET  = 16'd1000;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_SHOW
	} cmr_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;     // an input word is accepted this cycle
		logic fetch;    // read the frame store at the current word
		logic advance;  // current output word is taken, move to the next
	} cmr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic complete;   // the offered frame completes a message
		logic last_word;  // the current output word is the final one
		logic upper;      // the current output word is the upper half of a frame
	} cmr_status_t;

endpackage

>>> rtl/cmr_ram.sv
module cmr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port; registered read that holds when not enabled.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/cmr_datapath.sv
`include "can_multiframe_reassembler_unit_defines.svh"

module cmr_datapath
	import cmr_pkg::*;
#(
	parameter int MAX_FRAMES = 8,
	localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
	localparam int CW = AW + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [ID_W-1:0]       identifier,
	input  logic [PAYLOAD_W-1:0]  payload,
	input  logic [TIME_W-1:0]     now_ms,
	input  cmr_cmd_t              cmd,
	output cmr_status_t           st,
	output logic [INDEX_W-1:0]    word_index,
	output logic [WORD_W-1:0]     word_value
);

	logic [ID_W-1:0]       base_id_q;
	logic [TIMEOUT_W-1:0]  timeout_q;
	logic [COUNT_W-1:0]    count_q;
	logic [MAX_FRAMES-1:0] seen_q;
	logic [TIME_W-1:0]     last_time_q;
	logic                  open_q;
	logic [CW-1:0]         cnt_q;

	logic [FNUM_W-1:0]     fnum;
	logic [COUNT_W-1:0]    new_count;
	logic                  id_match;
	logic                  timed_out;
	logic                  open_eff;
	logic [MAX_FRAMES-1:0] seen_eff;
	logic [MAX_FRAMES-1:0] frame_bit;
	logic [MAX_FRAMES-1:0] full_mask;
	logic [MAX_FRAMES-1:0] seen_new;
	logic [TIME_W-1:0]     elapsed;
	logic                  bad_count;
	logic                  data_ok;
	logic                  complete;
	logic [FNUM_W-1:0]     fnum_m1;
	logic [PAYLOAD_W-1:0]  frame_rd;

	assign fnum      = identifier[FNUM_W-1:0];
	assign new_count = payload[COUNT_W-1:0];
	assign id_match  = ({identifier[ID_W-1:FNUM_W], {FNUM_W{1'b0}}} == base_id_q);
	assign elapsed   = now_ms - last_time_q;
	assign timed_out = open_q && (elapsed > TIME_W'(timeout_q));
	assign open_eff  = open_q && !timed_out;
	assign seen_eff  = timed_out ? '0 : seen_q;
	assign fnum_m1   = fnum - FNUM_W'(1);

	// Frame-number decode and the mask of frames the message needs.
	always_comb begin
		for (int j = 0; j < MAX_FRAMES; j++) begin
			frame_bit[j] = (fnum == FNUM_W'(j + 1));
			full_mask[j] = (COUNT_W'(j) < count_q);
		end
	end

	assign bad_count = (new_count == '0) || (new_count > COUNT_W'(MAX_FRAMES));
	assign data_ok   = id_match && (fnum != '0) && open_eff
		&& (COUNT_W'(fnum) <= count_q) && ((seen_eff & frame_bit) == '0);
	assign seen_new  = seen_eff | frame_bit;
	assign complete  = data_ok && ((seen_new & full_mask) == full_mask);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_id_q <= '0;
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BASE_ID:    base_id_q <= cfg_data[ID_W-1:0];
				REG_TIMEOUT_MS: timeout_q <= cfg_data[TIMEOUT_W-1:0];
			endcase
		end
	end

	// Session state, updated on each accepted word whose identifier matches the base.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			seen_q      <= '0;
			last_time_q <= '0;
			open_q      <= 1'b0;
		end else if (cmd.take && id_match) begin
			if (fnum == '0) begin
				count_q <= new_count;
				if (bad_count) begin
					open_q <= 1'b0;
					seen_q <= seen_eff;
				end else begin
					open_q      <= 1'b1;
					seen_q      <= '0;
					last_time_q <= now_ms;
				end
			end else if (data_ok) begin
				last_time_q <= now_ms;
				if (complete) begin
					open_q <= 1'b0;
					seen_q <= '0;
				end else begin
					open_q <= 1'b1;
					seen_q <= seen_new;
				end
			end else begin
				open_q <= open_eff;
				seen_q <= seen_eff;
			end
		end
	end

	// Output word counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.take) begin
			cnt_q <= '0;
		end else if (cmd.advance) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	// Frame store: written by data frames, read one frame per word pair.
	cmr_ram #(
		.WIDTH (PAYLOAD_W),
		.DEPTH (MAX_FRAMES)
	) u_store (
		.clk   (clk),
		.we    (cmd.take && data_ok),
		.waddr (fnum_m1[AW-1:0]),
		.wdata (payload),
		.re    (cmd.fetch),
		.raddr (cnt_q[AW:1]),
		.rdata (frame_rd)
	);

	assign st.complete  = complete;
	assign st.last_word = ((COUNT_W + 1)'(cnt_q) + (COUNT_W + 1)'(1)) == {count_q, 1'b0};
	assign st.upper     = cnt_q[0];

	assign word_index = INDEX_W'(cnt_q);
	assign word_value = cnt_q[0] ? frame_rd[PAYLOAD_W-1:WORD_W] : frame_rd[WORD_W-1:0];

	// An open session always holds a count in range.
	`CMR_ASSERT_NOW(a_open_count, open_q,
		(count_q != '0) && (count_q <= COUNT_W'(MAX_FRAMES)), "open session with bad count")
	// An open session never marks a frame beyond its count.
	`CMR_ASSERT_NOW(a_seen_range, open_q, (seen_q & ~full_mask) == '0,
		"seen frame beyond count")
	// A completing frame closes the session and restarts the word counter.
	`CMR_ASSERT_NEXT(a_complete_close, cmd.take && complete,
		!open_q && (seen_q == '0) && (cnt_q == '0), "session not closed on completion")

endmodule

>>> rtl/cmr_ctrl.sv
`include "can_multiframe_reassembler_unit_defines.svh"

module cmr_ctrl
	import cmr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	output logic        m_tvalid,
	input  logic        m_tready,
	input  cmr_status_t st,
	output cmr_cmd_t    cmd
);

	cmr_state_t state_q;
	cmr_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid && st.complete) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				state_d = ST_SHOW;
			end
			ST_SHOW: begin
				if (m_tready) begin
					if (st.last_word) begin
						state_d = ST_IDLE;
					end else if (st.upper) begin
						state_d = ST_FETCH;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs and datapath commands.
	always_comb begin
		s_tready    = 1'b0;
		m_tvalid    = 1'b0;
		cmd.take    = 1'b0;
		cmd.fetch   = 1'b0;
		cmd.advance = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.take = s_tvalid;
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
			end
			ST_SHOW: begin
				m_tvalid    = 1'b1;
				cmd.advance = m_tready && !st.last_word;
			end
			default: begin
			end
		endcase
	end

	// No frame is taken while a word is on offer.
	`CMR_ASSERT_NOW(a_no_overlap, m_tvalid, !s_tready, "input taken during output")
	// A store read is always followed by showing its word.
	`CMR_ASSERT_NEXT(a_fetch_show, state_q == ST_FETCH, state_q == ST_SHOW,
		"fetch not followed by show")
	// Taking the final word returns to idle.
	`CMR_ASSERT_NEXT(a_last_idle, m_tvalid && m_tready && st.last_word,
		state_q == ST_IDLE, "no return to idle after last word")

endmodule

>>> rtl/can_multiframe_reassembler_unit.sv
// Reassembles a multi-frame message from extended CAN frames. Frames whose identifier, with
// its low five bits cleared, differs from base_id are dropped; frame 0 opens a session and
// gives the frame count in payload byte 0, data frames 1..count are stored once each, and an
// open session is dropped after more than timeout_ms of silence. On the frame that completes
// a message the block stops taking input and sends 2*count little-endian 32-bit words, tlast
// on the final one. For each stored frame of a completed message it does one store read and
// then sends two words, as the frame store has a single read port; it takes no new frame
// until the final word is taken.
module can_multiframe_reassembler_unit
	import cmr_pkg::*;
#(
	parameter int MAX_FRAMES = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// identifier [28:0], payload [92:29], now_ms [124:93], zero fill [127:125]
	input  logic [S_TDATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// word_index [3:0], word_value [35:4], zero fill [39:36]
	output logic [M_TDATA_W-1:0]  m_tdata,
	output logic                  m_tlast
);

	cmr_cmd_t           cmd;
	cmr_status_t        st;
	logic [INDEX_W-1:0] word_index;
	logic [WORD_W-1:0]  word_value;

	// Session state, frame store and word selection.
	cmr_datapath #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.identifier (s_tdata[ID_W-1:0]),
		.payload    (s_tdata[ID_W+PAYLOAD_W-1:ID_W]),
		.now_ms     (s_tdata[ID_W+PAYLOAD_W+TIME_W-1:ID_W+PAYLOAD_W]),
		.cmd        (cmd),
		.st         (st),
		.word_index (word_index),
		.word_value (word_value)
	);

	// Handshake and output sequencing.
	cmr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.st       (st),
		.cmd      (cmd)
	);

	// Pack the output word.
	assign m_tdata = {{(M_TDATA_W - WORD_W - INDEX_W){1'b0}}, word_value, word_index};
	assign m_tlast = st.last_word;

endmodule
